/* design/tcptw_pkg.sv */
// Shared types and codes for the TCP time-wait / retransmit timer table.
`default_nettype none

package tcptw_pkg;

    localparam int SLOT_W    = 4;
    localparam int MASK_W    = 16;
    localparam int WAIT_W    = 16;
    localparam int BASE_W    = 12;
    localparam int RESEND_W  = 20;
    localparam int TRIES_W   = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    typedef enum logic [1:0] {
        CMD_TICK       = 2'd0,
        CMD_ARM_WAIT   = 2'd1,
        CMD_ARM_RESEND = 2'd2,
        CMD_DISARM     = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        EV_DONE   = 3'd0,
        EV_WAIT   = 3'd1,
        EV_RESEND = 3'd2,
        EV_ABORT  = 3'd3,
        EV_ACCEPT = 3'd4
    } ev_t;

    localparam logic [CFG_IDX_W-1:0] REG_TIMEWAIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 2'd2;

    // Controller to datapath
    typedef struct packed {
        logic              req_ready;
        logic              capture;
        logic              run_cmd;
        logic              run_slot;
        logic              run_done;
        logic [SLOT_W-1:0] idx;
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic req_valid;
        logic is_tick;
        logic out_free;
    } ctl_sts_t;

endpackage

`default_nettype wire

/* design/tcptw_ifs.sv */
// Valid/ready channel interfaces: command in, event out, register write.
`default_nettype none

interface tcptw_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [3:0]  slot;
    logic [15:0] pending_mask;

    modport source (output valid, output command, output slot, output pending_mask,
                    input ready);
    modport sink   (input valid, input command, input slot, input pending_mask,
                    output ready);
endinterface

interface tcptw_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_res;
    logic [3:0] event_slot;
    logic [2:0] attempt;
    logic       last;

    modport source (output valid, output event_res, output event_slot, output attempt,
                    output last, input ready);
    modport sink   (input valid, input event_res, input event_slot, input attempt,
                    input last, output ready);
endinterface

interface tcptw_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* design/tcptw_ctrl.sv */
// Sequencer: accepts an item, applies a command or walks the slots of a tick.
`default_nettype none

module tcptw_ctrl #(
    parameter int SLOTS = 16
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  tcptw_pkg::ctl_sts_t  sts,
    output tcptw_pkg::ctl_cmd_t  ctl
);
    import tcptw_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [SW-1:0] LAST_IDX = SW'(SLOTS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMD,
        ST_SCAN,
        ST_DONE
    } state_t;

    state_t        state_reg;
    logic [SW-1:0] idx_reg;

    always_comb
    begin
        ctl           = '0;
        ctl.idx       = SLOT_W'(idx_reg);
        ctl.req_ready = (state_reg == ST_IDLE);
        ctl.capture   = (state_reg == ST_IDLE) && sts.req_valid;
        ctl.run_cmd   = (state_reg == ST_CMD)  && sts.out_free;
        ctl.run_slot  = (state_reg == ST_SCAN) && sts.out_free;
        ctl.run_done  = (state_reg == ST_DONE) && sts.out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (sts.req_valid)
                    begin
                        idx_reg   <= '0;
                        state_reg <= sts.is_tick ? ST_SCAN : ST_CMD;
                    end
                end
                ST_CMD:
                begin
                    if (sts.out_free)
                        state_reg <= ST_IDLE;
                end
                ST_SCAN:
                begin
                    // advance one slot per free output cycle
                    if (sts.out_free)
                    begin
                        if (idx_reg == LAST_IDX)
                            state_reg <= ST_DONE;
                        else
                            idx_reg <= idx_reg + SW'(1);
                    end
                end
                ST_DONE:
                begin
                    if (sts.out_free)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.run_cmd, ctl.run_slot, ctl.run_done}))
        else $error("more than one datapath action in a cycle");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (idx_reg <= LAST_IDX))
        else $error("scan index beyond last slot");

    a_done_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.run_done |=> ctl.req_ready)
        else $error("not ready after tick done");

    a_scan_reaches_done: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.run_slot && idx_reg == LAST_IDX) |=> (state_reg == ST_DONE))
        else $error("scan did not finish after last slot");

endmodule

`default_nettype wire

/* design/tcptw_dp.sv */
// Timer storage, per-slot countdown/expiry logic, registers and output stage.
`default_nettype none

module tcptw_dp #(
    parameter int SLOTS = 16
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  tcptw_pkg::ctl_cmd_t  ctl,
    output tcptw_pkg::ctl_sts_t  sts,
    tcptw_req_if.sink            req,
    tcptw_rsp_if.source          rsp,
    tcptw_cfg_if.sink            cfg
);
    import tcptw_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // configuration
    logic [WAIT_W-1:0]  timewait_reg;
    logic [BASE_W-1:0]  base_reg;
    logic [TRIES_W-1:0] limit_reg;

    // captured item
    cmd_t              cmd_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [MASK_W-1:0] pend_reg;

    // timer table
    logic                wait_armed_reg   [SLOTS];
    logic [WAIT_W-1:0]   wait_left_reg    [SLOTS];
    logic                resend_armed_reg [SLOTS];
    logic [RESEND_W-1:0] resend_left_reg  [SLOTS];
    logic [TRIES_W-1:0]  resend_tries_reg [SLOTS];

    // output stage
    logic               out_valid_reg;
    ev_t                event_res_reg;
    logic [SLOT_W-1:0]  event_slot_reg;
    logic [TRIES_W-1:0] attempt_reg;
    logic               last_reg;

    logic [SW-1:0]       sel;
    logic [SW-1:0]       cmd_sel;
    logic                slot_ok;
    logic                w_arm;
    logic                r_arm;
    logic [TRIES_W-1:0]  r_tries;
    logic [WAIT_W-1:0]   w_dec;
    logic [RESEND_W-1:0] r_dec;
    logic [RESEND_W-1:0] backoff;
    logic                w_expire;
    logic                r_expire;
    logic                r_abort;
    logic                r_resend;
    logic                ev_hit;
    ev_t                 ev_code;
    logic                load;

    assign sel     = ctl.idx[SW-1:0];
    assign cmd_sel = slot_reg[SW-1:0];
    assign slot_ok = ({1'b0, slot_reg} < (SLOT_W + 1)'(SLOTS));

    // count down first, then judge expiry on the decremented values
    assign w_arm   = wait_armed_reg[sel];
    assign r_arm   = resend_armed_reg[sel];
    assign r_tries = resend_tries_reg[sel];
    assign w_dec   = (w_arm && wait_left_reg[sel] != '0)
                     ? wait_left_reg[sel] - WAIT_W'(1) : wait_left_reg[sel];
    assign r_dec   = (r_arm && resend_left_reg[sel] != '0)
                     ? resend_left_reg[sel] - RESEND_W'(1) : resend_left_reg[sel];
    assign backoff = {{(RESEND_W - BASE_W){1'b0}}, base_reg}
                     << ({1'b0, r_tries} + 4'd1);

    assign w_expire = w_arm && (w_dec == '0);
    assign r_expire = !w_expire && r_arm && (r_dec == '0);
    assign r_abort  = r_expire && (r_tries >= limit_reg);
    assign r_resend = r_expire && !r_abort && pend_reg[ctl.idx];
    assign ev_hit   = w_expire || r_abort || r_resend;

    always_comb
    begin
        priority if (w_expire)
            ev_code = EV_WAIT;
        else if (r_abort)
            ev_code = EV_ABORT;
        else
            ev_code = EV_RESEND;
    end

    assign load = ctl.run_cmd || (ctl.run_slot && ev_hit) || ctl.run_done;

    assign sts.req_valid = req.valid;
    assign sts.is_tick   = (cmd_t'(req.command) == CMD_TICK);
    assign sts.out_free  = !out_valid_reg || rsp.ready;

    assign req.ready      = ctl.req_ready;
    assign cfg.ready      = 1'b1;
    assign rsp.valid      = out_valid_reg;
    assign rsp.event_res  = event_res_reg;
    assign rsp.event_slot = event_slot_reg;
    assign rsp.attempt    = attempt_reg;
    assign rsp.last       = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timewait_reg <= WAIT_W'(400);
            base_reg     <= BASE_W'(20);
            limit_reg    <= TRIES_W'(3);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_TIMEWAIT: timewait_reg <= cfg.data;
                REG_BASE:     base_reg     <= cfg.data[BASE_W-1:0];
                REG_LIMIT:    limit_reg    <= cfg.data[TRIES_W-1:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg  <= cmd_t'(req.command);
            slot_reg <= req.slot;
            pend_reg <= req.pending_mask;
        end
    end

    // armed flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SLOTS; s++)
            begin
                wait_armed_reg[s]   <= 1'b0;
                resend_armed_reg[s] <= 1'b0;
            end
        end
        else if (ctl.run_cmd && slot_ok)
        begin
            unique case (cmd_reg)
                CMD_ARM_WAIT:   wait_armed_reg[cmd_sel]   <= 1'b1;
                CMD_ARM_RESEND: resend_armed_reg[cmd_sel] <= 1'b1;
                CMD_DISARM:     resend_armed_reg[cmd_sel] <= 1'b0;
                CMD_TICK:       ;
                default:        ;
            endcase
        end
        else if (ctl.run_slot)
        begin
            if (w_expire)
                wait_armed_reg[sel] <= 1'b0;
            if (r_abort)
                resend_armed_reg[sel] <= 1'b0;
        end
    end

    // counters and try counts, only meaningful while armed
    always_ff @(posedge clk)
    begin
        if (ctl.run_cmd && slot_ok)
        begin
            unique case (cmd_reg)
                CMD_ARM_WAIT:   wait_left_reg[cmd_sel] <= timewait_reg;
                CMD_ARM_RESEND:
                begin
                    resend_left_reg[cmd_sel]  <= RESEND_W'(base_reg);
                    resend_tries_reg[cmd_sel] <= '0;
                end
                CMD_DISARM:     ;
                CMD_TICK:       ;
                default:        ;
            endcase
        end
        else if (ctl.run_slot)
        begin
            wait_left_reg[sel] <= w_dec;
            if (r_resend)
            begin
                resend_left_reg[sel]  <= backoff;
                resend_tries_reg[sel] <= r_tries + TRIES_W'(1);
            end
            else
                resend_left_reg[sel] <= r_dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (rsp.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.run_cmd)
        begin
            event_res_reg  <= EV_ACCEPT;
            event_slot_reg <= '0;
            attempt_reg    <= '0;
            last_reg       <= 1'b1;
        end
        else if (ctl.run_slot && ev_hit)
        begin
            event_res_reg  <= ev_code;
            event_slot_reg <= ctl.idx;
            attempt_reg    <= r_resend ? r_tries + TRIES_W'(1) : '0;
            last_reg       <= 1'b0;
        end
        else if (ctl.run_done)
        begin
            event_res_reg  <= EV_DONE;
            event_slot_reg <= '0;
            attempt_reg    <= '0;
            last_reg       <= 1'b1;
        end
    end

    a_cmd_answer: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.run_cmd |=> (rsp.valid && rsp.last && rsp.event_res == EV_ACCEPT))
        else $error("command not answered with accept");

    a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.run_slot |-> $onehot0({w_expire, r_abort, r_resend}))
        else $error("more than one event for a slot");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (load && out_valid_reg) |-> rsp.ready)
        else $error("pending result overwritten");

endmodule

`default_nettype wire

/* design/tcp_timewait_retransmit_timer_table.sv */
// Top level of the per-connection time-wait and retransmit timer table.
`default_nettype none

// Holds one time-wait and one retransmit timer for each of SLOTS connection
// slots. An arm or disarm command is first transferred, then applied, and
// the "command accepted" result is posted. In a tick the sequencer visits
// one slot per cycle while the output is free, counting both timers down
// and reporting at most one event for the slot, then posts "tick done" with
// last set. Events leave in ascending slot order through a one-entry output
// register; a stalled output holds the sequencer on the current slot. A new
// item is taken only after the previous one has posted its final result.
// Registers may be written at any time the block is idle; the write channel
// is always ready.
module tcp_timewait_retransmit_timer_table #(
    parameter int SLOTS = 16
) (
    input  wire         clk,
    input  wire         rst_n,
    tcptw_req_if.sink   req,
    tcptw_rsp_if.source rsp,
    tcptw_cfg_if.sink   cfg
);
    import tcptw_pkg::*;

    ctl_cmd_t ctl;
    ctl_sts_t sts;

    tcptw_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .ctl   (ctl)
    );

    tcptw_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .sts   (sts),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

endmodule

`default_nettype wire
